// ===== hdl/htd_pkg.sv =====
// Shared types and constants of the Huffman tree text decoder.
package htd_pkg;

   localparam int IDX_W     = 8;
   localparam int SYM_W     = 8;
   localparam int PHASE_W   = 2;
   localparam int BITPOS_W  = 3;
   localparam int OP_W      = 2;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 8;
   localparam int NODE_W    = 2 * IDX_W + SYM_W;

   localparam logic [BITPOS_W-1:0] TOP_BIT = 3'd7;

   localparam logic [OP_W-1:0] OP_WRITE_NODE = 2'd0;
   localparam logic [OP_W-1:0] OP_START      = 2'd1;
   localparam logic [OP_W-1:0] OP_DATA       = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] left_child;
      logic [IDX_W-1:0] right_child;
      logic [SYM_W-1:0] leaf_symbol;
   } node_type;

   typedef struct packed {
      logic [REQ_W-43:0]   pad;
      logic [SYM_W-1:0]    data_byte;
      logic [PHASE_W-1:0]  start_phase;
      logic [SYM_W-1:0]    leaf_symbol;
      logic [IDX_W-1:0]    right_child;
      logic [IDX_W-1:0]    left_child;
      logic [IDX_W-1:0]    node_index;
   } req_type;

endpackage

// ===== hdl/huffman_tree_text_decoder.sv =====
// Top level of the Huffman tree text decoder.
//
// Items arrive on the req_ stream; tuser carries the operation. A node-write
// item loads one entry of the node table, a start item opens a message at the
// given phase, and a data item feeds one compressed byte into the tree walk.
// Node-write, start and ignored items are handled without leaving idle.
// A data item first fetches the current walk node, then the next node for
// each bit of the byte (up to eight), checks the node reached by the last
// bit and hands over its last symbol; each bit makes a dependent read of
// the node memory. Decoded symbols leave on the rsp_ stream;
// tuser flags the terminator and tlast marks the last symbol of a byte.
// One symbol is held back until the next one or the end of the byte shows
// whether it is the last. When the receiver stalls, the walk waits with its
// node read held; new items are accepted again once the byte is finished.
// Reset closes any message, puts the walk at the root and empties the output;
// the node table keeps no reset value and must be written before use.
module huffman_tree_text_decoder #(
   parameter int NODE_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // node_index, left_child, right_child, leaf_symbol, start_phase, data_byte
   input  logic [htd_pkg::REQ_W-1:0]     req_tdata,
   // operation
   input  logic [htd_pkg::OP_W-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // symbol
   output logic [htd_pkg::RSP_W-1:0]     rsp_tdata,
   // message_end
   output logic [0:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   import htd_pkg::*;

   localparam int ADDR_W = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   req_type req;
   node_type node;
   node_type ram_rdata;
   node_type wr_node;

   logic [1:0]          state_ff, state_in;
   logic                active_ff, active_in;
   logic [BITPOS_W-1:0] first_bit_ff, first_bit_in;
   logic [IDX_W-1:0]    walk_ff, walk_in;
   logic [SYM_W-1:0]    byte_ff, byte_in;
   logic [BITPOS_W-1:0] bit_ff, bit_in;
   logic                last_bit_ff, last_bit_in;
   logic                have_child_ff, have_child_in;
   logic                oor_ff, oor_in;
   logic [IDX_W-1:0]    child_ff, child_in;
   logic [IDX_W-1:0]    root_left_ff, root_left_in;
   logic [IDX_W-1:0]    root_right_ff, root_right_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]    pend_sym_ff, pend_sym_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  rd_index;
   logic              out_free;
   logic              is_leaf;
   logic [IDX_W-1:0]  cur_left;
   logic [IDX_W-1:0]  cur_right;
   logic [IDX_W-1:0]  next_index;

   assign req        = req_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign wr_node.left_child  = req.left_child;
   assign wr_node.right_child = req.right_child;
   assign wr_node.leaf_symbol = req.leaf_symbol;

   assign ram_wr_en = accept && (req_tuser == OP_WRITE_NODE)
                      && ({24'd0, req.node_index} < NODE_COUNT);

   htd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req.node_index)),
      .wr_data (wr_node),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(rd_index)),
      .rd_data (ram_rdata)
   );

   assign node    = oor_ff ? node_type'('0) : ram_rdata;
   assign is_leaf = (node.left_child == '0) && (node.right_child == '0);

   always_comb begin
      if (have_child_ff && is_leaf) begin
         cur_left  = root_left_ff;
         cur_right = root_right_ff;
      end else begin
         cur_left  = node.left_child;
         cur_right = node.right_child;
      end
      next_index = byte_ff[bit_ff] ? cur_right : cur_left;
   end

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      first_bit_in  = first_bit_ff;
      walk_in       = walk_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      last_bit_in   = last_bit_ff;
      have_child_in = have_child_ff;
      oor_in        = oor_ff;
      child_in      = child_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      ram_rd_en     = 1'b0;
      rd_index      = walk_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_tuser == OP_WRITE_NODE) begin
                  if (req.node_index == '0) begin
                     root_left_in  = req.left_child;
                     root_right_in = req.right_child;
                  end
               end else if (req_tuser == OP_START) begin
                  first_bit_in = TOP_BIT - {req.start_phase, 1'b0};
                  walk_in      = '0;
                  active_in    = 1'b1;
               end else if (req_tuser == OP_DATA && active_ff) begin
                  ram_rd_en     = 1'b1;
                  rd_index      = walk_ff;
                  oor_in        = !({24'd0, walk_ff} < NODE_COUNT);
                  byte_in       = req.data_byte;
                  bit_in        = first_bit_ff;
                  first_bit_in  = TOP_BIT;
                  have_child_in = 1'b0;
                  state_in      = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            if (!(have_child_ff && is_leaf && pend_valid_ff && !out_free)) begin
               if (have_child_ff && is_leaf) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = node.leaf_symbol;
                  walk_in       = '0;
               end else if (have_child_ff) begin
                  walk_in = child_ff;
               end
               if (have_child_ff && is_leaf && node.leaf_symbol == '0) begin
                  active_in = 1'b0;
                  state_in  = ST_FLUSH;
               end else if (have_child_ff && last_bit_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  ram_rd_en     = 1'b1;
                  rd_index      = next_index;
                  oor_in        = !({24'd0, next_index} < NODE_COUNT);
                  child_in      = next_index;
                  last_bit_in   = (bit_ff == '0);
                  bit_in        = BITPOS_W'(bit_ff - 3'd1);
                  have_child_in = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         first_bit_ff  <= TOP_BIT;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         first_bit_ff  <= first_bit_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      bit_ff        <= bit_in;
      last_bit_ff   <= last_bit_in;
      have_child_ff <= have_child_in;
      oor_ff        <= oor_in;
      child_ff      <= child_in;
      root_left_ff  <= root_left_in;
      root_right_ff <= root_right_in;
      pend_sym_ff   <= pend_sym_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_sym_ff;
   assign rsp_tuser[0] = (rsp_sym_ff == '0);
   assign rsp_tlast    = rsp_last_ff;

endmodule

// ===== hdl/htd_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module htd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
